/* rtl/core/hft_pkg.sv */
// Shared constants, queue entry type and FCS helpers for the HDLC frame transmitter.
package hft_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] FCS_POLY  = 16'h8408;
  localparam logic [15:0] FCS_INIT  = 16'hFFFF;

  localparam int unsigned HFT_QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [15:0] fcs;
    logic        frame_end;
    logic        frame_start;
    logic [7:0]  data_byte;
  } hft_entry_t;

  function automatic logic [15:0] fcs_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ FCS_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

endpackage

/* rtl/core/hdlc_frame_transmitter.sv */
// Top level of the HDLC frame transmitter: front end, entry queue and byte sequencer.
//
//   channel  | dir | tdata          | tlast        | tuser
//   s_axis   | in  | data_byte[7:0] | frame_end    | frame_start
//   m_axis   | out | line_byte[7:0] | last_of_run  | -
//
// One line byte leaves per cycle while the output is not stalled; an input beat yields
// 1 to 8 line bytes: 1 for a plain content byte with no marks, 2 for an escaped one,
// 8 at most. The byte sequencer sets the rate.
// The front end takes a beat each cycle while the queue has room; queue depth is Depth.
// Reset clears the FCS to all ones, empties the queue and drops any pending output beat.
// An output stall holds the beat; the front end keeps accepting until the queue fills.
module hdlc_frame_transmitter #(
  parameter int unsigned Depth = hft_pkg::HFT_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] data_byte
  input  logic       s_axis_tlast_i,
  input  logic       s_axis_tuser_i,  // [0] frame_start
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] line_byte
  output logic       m_axis_tlast_o
);
  import hft_pkg::*;

  logic       push;
  hft_entry_t push_entry;
  logic       q_full;
  logic       pop;
  logic       q_valid;
  hft_entry_t head;

  hft_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .data_byte_i   (s_axis_tdata_i),
    .frame_start_i (s_axis_tuser_i),
    .frame_end_i   (s_axis_tlast_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_entry_o  (push_entry)
  );

  hft_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .head_o       (head)
  );

  hft_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .line_byte_o   (m_axis_tdata_o),
    .last_of_run_o (m_axis_tlast_o)
  );

endmodule

/* rtl/core/hft_front.sv */
// Front end: accept content bytes, run the FCS and build queue entries.
module hft_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              frame_start_i,
  input  logic              frame_end_i,
  input  logic              q_full_i,
  output logic              push_o,
  output hft_pkg::hft_entry_t push_entry_o
);
  import hft_pkg::*;

  logic [15:0] fcs_q, fcs_d;
  logic [15:0] fcs_new;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    fcs_new = fcs_update(frame_start_i ? FCS_INIT : fcs_q, data_byte_i);
    fcs_d   = fcs_q;
    if (push_o) begin
      fcs_d = frame_end_i ? ~fcs_new : fcs_new;
    end
    push_entry_o.data_byte   = data_byte_i;
    push_entry_o.frame_start = frame_start_i;
    push_entry_o.frame_end   = frame_end_i;
    push_entry_o.fcs         = ~fcs_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcs_q <= FCS_INIT;
    end else begin
      fcs_q <= fcs_d;
    end
  end

endmodule

/* rtl/core/hft_queue.sv */
// Short entry queue between the front end and the byte sequencer.
module hft_queue #(
  parameter int unsigned Depth = hft_pkg::HFT_QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hft_pkg::hft_entry_t push_entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output hft_pkg::hft_entry_t head_o
);
  import hft_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  hft_entry_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

/* rtl/core/hft_back.sv */
// Back end: expand each queue entry into stuffed line bytes behind an output register.
module hft_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  hft_pkg::hft_entry_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          line_byte_o,
  output logic                last_of_run_o
);
  import hft_pkg::*;

  localparam logic [2:0] S_OPEN  = 3'd0;
  localparam logic [2:0] S_DESC  = 3'd1;
  localparam logic [2:0] S_DATA  = 3'd2;
  localparam logic [2:0] S_LESC  = 3'd3;
  localparam logic [2:0] S_LOW   = 3'd4;
  localparam logic [2:0] S_HESC  = 3'd5;
  localparam logic [2:0] S_HIGH  = 3'd6;
  localparam logic [2:0] S_CLOSE = 3'd7;

  logic       first_q, first_d;
  logic [2:0] step_q, step_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;

  logic [7:0] app;
  logic [7:0] after;
  logic [2:0] first_step;
  logic [2:0] cur;
  logic [2:0] next_step;
  logic       is_last;
  logic       load;
  logic       emit;
  logic       esc_data, esc_low, esc_high;
  logic [7:0] line_byte;

  assign esc_data = needs_esc(head_i.data_byte);
  assign esc_low  = needs_esc(head_i.fcs[7:0]);
  assign esc_high = needs_esc(head_i.fcs[15:8]);

  always_comb begin
    app[S_OPEN]  = head_i.frame_start;
    app[S_DESC]  = esc_data;
    app[S_DATA]  = 1'b1;
    app[S_LESC]  = head_i.frame_end && esc_low;
    app[S_LOW]   = head_i.frame_end;
    app[S_HESC]  = head_i.frame_end && esc_high;
    app[S_HIGH]  = head_i.frame_end;
    app[S_CLOSE] = head_i.frame_end;
  end

  always_comb begin
    logic found;
    found      = 1'b0;
    first_step = S_DATA;
    for (int i = 0; i < 8; i++) begin
      if (app[i] && !found) begin
        first_step = 3'(i);
        found      = 1'b1;
      end
    end
  end

  assign cur = first_q ? first_step : step_q;

  always_comb begin
    logic found;
    found     = 1'b0;
    next_step = S_CLOSE;
    for (int i = 0; i < 8; i++) begin
      after[i] = app[i] && (3'(i) > cur);
    end
    for (int i = 0; i < 8; i++) begin
      if (after[i] && !found) begin
        next_step = 3'(i);
        found     = 1'b1;
      end
    end
    is_last = !found;
  end

  always_comb begin
    case (cur)
      S_OPEN:  line_byte = FLAG_BYTE;
      S_DESC:  line_byte = ESC_BYTE;
      S_DATA:  line_byte = head_i.data_byte ^ (esc_data ? ESC_XOR : 8'h00);
      S_LESC:  line_byte = ESC_BYTE;
      S_LOW:   line_byte = head_i.fcs[7:0] ^ (esc_low ? ESC_XOR : 8'h00);
      S_HESC:  line_byte = ESC_BYTE;
      S_HIGH:  line_byte = head_i.fcs[15:8] ^ (esc_high ? ESC_XOR : 8'h00);
      S_CLOSE: line_byte = FLAG_BYTE;
      default: line_byte = FLAG_BYTE;
    endcase
  end

  assign load  = !valid_q || out_ready_i;
  assign emit  = load && q_valid_i;
  assign pop_o = emit && is_last;

  always_comb begin
    first_d = first_q;
    step_d  = step_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (load) begin
      valid_d = q_valid_i;
    end
    if (emit) begin
      byte_d  = line_byte;
      last_d  = is_last;
      first_d = is_last;
      step_d  = next_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      step_q  <= S_OPEN;
      valid_q <= 1'b0;
    end else begin
      first_q <= first_d;
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o   = valid_q;
  assign line_byte_o   = byte_q;
  assign last_of_run_o = last_q;

endmodule

/* rtl/core/hft_checker.sv */
// Port-level checks for the HDLC frame transmitter, bound to the top level.
module hft_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);
  import hft_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  a_esc_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o == ESC_BYTE) |-> !m_axis_tlast_o)
    else $error("escape beat marked as last");

  a_esc_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && (m_axis_tdata_o == ESC_BYTE) |=>
      m_axis_tvalid_o && ((m_axis_tdata_o == (FLAG_BYTE ^ ESC_XOR)) ||
                          (m_axis_tdata_o == (ESC_BYTE ^ ESC_XOR))))
    else $error("escape beat not followed by an escaped byte");

endmodule

bind hdlc_frame_transmitter hft_checker u_hft_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

/* bench/hdlc_frame_transmitter_test.sv */
// Self-checking bench for the HDLC frame transmitter: random and directed frames, FCS-16 check.
import hft_pkg::*;

class hdlc_line_scoreboard;
  typedef struct {
    logic [7:0] line_byte;
    logic       last_of_run;
  } line_beat_t;

  line_beat_t  expected_line_beats[$];
  logic [15:0] fcs_running;
  int unsigned mismatches;
  int unsigned beats_seen;

  function new();
    fcs_running = FCS_INIT;
    mismatches  = 0;
    beats_seen  = 0;
  endfunction

  static function logic [15:0] fcs_next(logic [15:0] crc, logic [7:0] b);
    logic        fb;
    logic [15:0] r;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ FCS_POLY;
      end
    end
    return r;
  endfunction

  function void push_line(logic [7:0] b);
    line_beat_t e;
    e.line_byte   = b;
    e.last_of_run = 1'b0;
    expected_line_beats.push_back(e);
  endfunction

  function void push_stuffed(logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE) begin
      push_line(ESC_BYTE);
      push_line(b ^ ESC_XOR);
    end else begin
      push_line(b);
    end
  endfunction

  function void note_content_byte(logic [7:0] data, logic start, logic stop);
    if (start) begin
      fcs_running = FCS_INIT;
      push_line(FLAG_BYTE);
    end
    fcs_running = fcs_next(fcs_running, data);
    push_stuffed(data);
    if (stop) begin
      fcs_running = ~fcs_running;
      push_stuffed(fcs_running[7:0]);
      push_stuffed(fcs_running[15:8]);
      push_line(FLAG_BYTE);
    end
    expected_line_beats[expected_line_beats.size() - 1].last_of_run = 1'b1;
  endfunction

  function void check_line_beat(logic [7:0] line_byte, logic last_of_run);
    line_beat_t e;
    beats_seen++;
    if (expected_line_beats.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected beat line_byte=%02h last_of_run=%0b",
               $time, line_byte, last_of_run);
      return;
    end
    e = expected_line_beats.pop_front();
    if (line_byte !== e.line_byte) begin
      mismatches++;
      $display("%0t: line_byte expected %02h actual %02h", $time, e.line_byte, line_byte);
    end
    if (last_of_run !== e.last_of_run) begin
      mismatches++;
      $display("%0t: last_of_run expected %0b actual %0b",
               $time, e.last_of_run, last_of_run);
    end
  endfunction

  function int pending();
    return expected_line_beats.size();
  endfunction
endclass

module hdlc_frame_transmitter_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;   // [7:0] data_byte
  logic       s_axis_tlast_i;   // frame_end
  logic       s_axis_tuser_i;   // [0] frame_start
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;   // [7:0] line_byte
  logic       m_axis_tlast_o;   // last_of_run

  hdlc_line_scoreboard line_sb;
  int unsigned         items_sent;
  bit                  holdoff_done;

  hdlc_frame_transmitter DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_content_byte(logic [7:0] data, logic start, logic stop);
    int unsigned gap;
    gap = ((items_sent / 40) % 2 == 1) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tuser_i  <= start;
    s_axis_tlast_i  <= stop;
    do @(posedge clk_i); while (!s_axis_tready_o);
    line_sb.note_content_byte(data, start, stop);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_line();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (line_sb.pending() != 0);
  endtask

  function automatic logic [7:0] pick_content();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      b = $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
    end
    return b;
  endfunction

  // receive side: random stalls, calm stretches, one long hold-off
  initial begin
    int unsigned stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!holdoff_done && line_sb.beats_seen >= 60) begin
        holdoff_done = 1'b1;
        stall = 120;
      end else begin
        stall = ((line_sb.beats_seen / 50) % 3 == 2) ? 0 : $urandom_range(0, 3);
      end
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      line_sb.check_line_beat(m_axis_tdata_o, m_axis_tlast_o);
      @(negedge clk_i);
    end
  end

  initial begin
    logic [7:0]  lo_hit;
    logic [7:0]  hi_hit;
    logic [15:0] f;
    bit          lo_found;
    bit          hi_found;
    int unsigned len;
    line_sb         = new();
    items_sent      = 0;
    lo_found        = 1'b0;
    hi_found        = 1'b0;
    lo_hit          = 8'h00;
    hi_hit          = 8'h00;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tlast_i  = 1'b0;
    s_axis_tuser_i  = 1'b0;

    // find one-byte frames whose FCS bytes need escaping
    for (int b = 0; b < 256; b++) begin
      f = ~line_sb.fcs_next(FCS_INIT, b[7:0]);
      if (!lo_found && (f[7:0] == FLAG_BYTE || f[7:0] == ESC_BYTE)) begin
        lo_found = 1'b1;
        lo_hit   = b[7:0];
      end
      if (!hi_found && (f[15:8] == FLAG_BYTE || f[15:8] == ESC_BYTE)) begin
        hi_found = 1'b1;
        hi_hit   = b[7:0];
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_content_byte(8'h00, 1'b0, 1'b0);
    send_content_byte(8'h41, 1'b0, 1'b1);
    send_content_byte(8'h00, 1'b1, 1'b1);
    send_content_byte(8'hFF, 1'b1, 1'b1);
    send_content_byte(FLAG_BYTE, 1'b1, 1'b1);
    send_content_byte(ESC_BYTE, 1'b1, 1'b1);
    send_content_byte(8'hFF, 1'b1, 1'b0);
    send_content_byte(8'h03, 1'b0, 1'b0);
    send_content_byte(FLAG_BYTE, 1'b0, 1'b0);
    send_content_byte(ESC_BYTE, 1'b0, 1'b0);
    send_content_byte(8'h5E, 1'b0, 1'b1);
    send_content_byte(8'hA5, 1'b0, 1'b0);
    send_content_byte(8'h5A, 1'b0, 1'b1);
    send_content_byte(8'h11, 1'b1, 1'b0);
    send_content_byte(8'h22, 1'b1, 1'b0);
    send_content_byte(8'h33, 1'b0, 1'b1);
    if (lo_found) begin
      send_content_byte(lo_hit, 1'b1, 1'b1);
    end
    if (hi_found) begin
      send_content_byte(hi_hit, 1'b1, 1'b1);
    end
    send_content_byte(8'h80, 1'b0, 1'b0);
    send_content_byte(8'h01, 1'b0, 1'b0);

    while (items_sent < 200) begin
      if (items_sent >= 120 && items_sent < 128) begin
        drain_line();
      end
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          send_content_byte(pick_content(), i == 0, i == len - 1);
        end
      end else begin
        send_content_byte(pick_content(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
      end
    end

    drain_line();
    repeat (30) @(posedge clk_i);
    if (line_sb.mismatches == 0 && line_sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/core/hft_pkg.sv
rtl/core/hft_front.sv
rtl/core/hft_queue.sv
rtl/core/hft_back.sv
rtl/core/hdlc_frame_transmitter.sv
rtl/core/hft_checker.sv
bench/hdlc_frame_transmitter_test.sv
